FILE: rtl/rtc_pkg.sv
package rtc_pkg;

    // Default sizing of the reply format
    localparam int FIELD_COUNT_DEF     = 12;
    localparam int MAX_FIELD_CHARS_DEF = 5;

    // Fields that have a template, and bytes kept of the captured field
    localparam int TEMPLATE_TOTAL = 12;
    localparam int TEXT_BYTES     = 5;

    // Depth of the token queue between the front and the back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Special bytes
    localparam logic [7:0] END_BYTE   = 8'd13;
    localparam logic [7:0] SPACE_BYTE = 8'd32;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;
    localparam logic [7:0] DOT_BYTE   = 8'h2e;

    // Configuration register indexes and reset values
    localparam logic CFG_MIN_LENGTH    = 1'b0;
    localparam logic CFG_CAPTURE_FIELD = 1'b1;

    localparam logic [7:0] MIN_LENGTH_RST    = 8'd40;
    localparam logic [3:0] CAPTURE_FIELD_RST = 4'd10;

    // Template character classes
    localparam logic [1:0] TC_ANY   = 2'd0;
    localparam logic [1:0] TC_DIGIT = 2'd1;
    localparam logic [1:0] TC_DOT   = 2'd2;

    typedef logic [TEXT_BYTES-1:0][1:0] t_tmpl_row;

    // Byte classes passed from the front to the back
    typedef enum logic [1:0] {
        TK_SKIP,
        TK_CHAR,
        TK_SPACE,
        TK_END
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [7:0] data;
        logic       is_digit;
        logic       is_dot;
    } t_token;

    // Template length of a field
    function automatic logic [2:0] tmpl_len(input logic [3:0] field);
        logic [2:0] len;
        unique case (field)
            4'd0, 4'd2, 4'd8:               len = 3'd5;
            4'd1, 4'd3, 4'd4, 4'd5, 4'd11:  len = 3'd4;
            4'd6, 4'd7, 4'd9, 4'd10:        len = 3'd3;
            default:                        len = 3'd0;
        endcase
        return len;
    endfunction

    // Template classes of a field, character 0 in the lowest slot
    function automatic t_tmpl_row tmpl_row(input logic [3:0] field);
        t_tmpl_row row;
        unique case (field)
            4'd0, 4'd2:  row = {TC_DIGIT, TC_DOT, TC_DIGIT, TC_DIGIT, TC_DIGIT};
            4'd1, 4'd3:  row = {TC_ANY, TC_DIGIT, TC_DOT, TC_DIGIT, TC_DIGIT};
            4'd4, 4'd5:  row = {TC_ANY, TC_DIGIT, TC_DIGIT, TC_DIGIT, TC_DIGIT};
            4'd6, 4'd9:  row = {TC_ANY, TC_ANY, TC_DIGIT, TC_DIGIT, TC_DIGIT};
            4'd8:        row = {TC_DIGIT, TC_ANY, TC_DOT, TC_ANY, TC_ANY};
            4'd10:       row = {TC_ANY, TC_ANY, TC_DIGIT, TC_DIGIT, TC_ANY};
            4'd11:       row = {TC_ANY, TC_DIGIT, TC_ANY, TC_DIGIT, TC_DIGIT};
            default:     row = {TC_ANY, TC_ANY, TC_ANY, TC_ANY, TC_ANY};
        endcase
        return row;
    endfunction

endpackage

FILE: rtl/response_template_checker.sv
// Status reply checker. Reply bytes enter on the input channel
// (i_in_valid / o_in_stall, byte on i_rx_byte), one transaction per byte.
// The first byte of a reply is skipped; the carriage return ends it.
// Each carriage return produces one transaction on the output channel
// (o_out_valid / i_out_stall) carrying o_reply_valid, o_field_text and
// o_field_length; other bytes produce nothing.
// Throughput is one byte per cycle while the queue has room: the front
// classifies a byte as it is taken, a two-entry token queue feeds the
// back, and the back updates the field counters and the capture buffer
// once per token. An accepted carriage return is written into the queue,
// then reaches o_out_valid through the back's result register.
// When the receiver stalls, the result is held; the back keeps working on
// non-return bytes, and the input stalls only once the queue is full.
// Registers are written on the config channel (i_cfg_valid, always ready):
// index 0 is min_length (reset 40), index 1 is capture_field (reset 10).
// Synchronous reset clears the reply state and restores the registers.
module response_template_checker import rtc_pkg::*; #(
    parameter int FIELD_COUNT     = FIELD_COUNT_DEF,
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic        o_reply_valid,
    output logic [39:0] o_field_text,
    output logic [2:0]  o_field_length,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_min_length;
    logic [3:0] r_capture_field;

    logic   q_full;
    logic   q_valid;
    logic   push;
    logic   pop;
    t_token front_token;
    t_token back_token;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length    <= MIN_LENGTH_RST;
            r_capture_field <= CAPTURE_FIELD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_LENGTH:    r_min_length    <= i_cfg_data;
                CFG_CAPTURE_FIELD: r_capture_field <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    rtc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_byte  (i_rx_byte),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_token    (front_token)
    );

    rtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_token (back_token)
    );

    rtc_back #(
        .FIELD_COUNT     (FIELD_COUNT),
        .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_token         (back_token),
        .o_pop           (pop),
        .i_min_length    (r_min_length),
        .i_capture_field (r_capture_field),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_reply_valid   (o_reply_valid),
        .o_field_text    (o_field_text),
        .o_field_length  (o_field_length)
    );

endmodule

FILE: rtl/rtc_front.sv
module rtc_front import rtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_rx_byte,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_token     o_token
);

    logic r_at_start;
    logic n_at_start;

    // Accept whenever the queue has room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classify the byte
    always_comb begin
        o_token.data     = i_rx_byte;
        o_token.is_digit = (i_rx_byte >= DIGIT_LO) && (i_rx_byte <= DIGIT_HI);
        o_token.is_dot   = (i_rx_byte == DOT_BYTE);
        if (i_rx_byte == END_BYTE) begin
            o_token.kind = TK_END;
        end else if (r_at_start) begin
            o_token.kind = TK_SKIP;
        end else if (i_rx_byte == SPACE_BYTE) begin
            o_token.kind = TK_SPACE;
        end else begin
            o_token.kind = TK_CHAR;
        end
    end

    // Track the start of a reply
    always_comb begin
        n_at_start = r_at_start;
        if (o_push) begin
            n_at_start = (i_rx_byte == END_BYTE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start <= 1'b1;
        end else begin
            r_at_start <= n_at_start;
        end
    end

endmodule

FILE: rtl/rtc_queue.sv
module rtc_queue import rtc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_token o_token
);

    t_token                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;
    logic [QUEUE_AW-1:0]   n_wr_ptr;
    logic [QUEUE_AW-1:0]   n_rd_ptr;
    logic [QUEUE_AW:0]     n_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed token
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

endmodule

FILE: rtl/rtc_back.sv
module rtc_back import rtc_pkg::*; #(
    parameter int FIELD_COUNT     = FIELD_COUNT_DEF,
    parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_token      i_token,
    output logic        o_pop,
    input  logic [7:0]  i_min_length,
    input  logic [3:0]  i_capture_field,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_reply_valid,
    output logic [39:0] o_field_text,
    output logic [2:0]  o_field_length
);

    localparam logic [3:0] FieldCountW = 4'(FIELD_COUNT);
    localparam logic [3:0] TmplTotalW  = 4'(TEMPLATE_TOTAL);
    localparam int         CapLimitI   = (MAX_FIELD_CHARS < TEXT_BYTES) ?
                                         MAX_FIELD_CHARS : TEXT_BYTES;
    localparam logic [2:0] CapLimit    = 3'(CapLimitI);

    logic [7:0]                 r_byte_count,  n_byte_count;
    logic [3:0]                 r_field_index, n_field_index;
    logic [2:0]                 r_char_index,  n_char_index;
    logic                       r_mismatch,    n_mismatch;
    logic [TEXT_BYTES-1:0][7:0] r_cap_buf,     n_cap_buf;
    logic [2:0]                 r_cap_count,   n_cap_count;
    logic                       r_out_valid,   n_out_valid;
    logic                       r_reply_valid, n_reply_valid;
    logic [39:0]                r_field_text,  n_field_text;
    logic [2:0]                 r_field_length, n_field_length;

    logic       checked;
    logic [2:0] cur_len;
    t_tmpl_row  cur_row;
    logic       close_mis;
    logic       end_mis;
    logic [3:0] fi_inc;
    logic [7:0] bc_inc;

    // Pop any non-return token; a return waits until the output slot is free
    assign o_pop = i_q_valid &&
                   (i_token.kind != TK_END || !r_out_valid || !i_out_stall);

    assign checked   = (r_field_index < FieldCountW) && (r_field_index < TmplTotalW);
    assign cur_len   = tmpl_len(r_field_index);
    assign cur_row   = tmpl_row(r_field_index);
    assign close_mis = checked && (r_char_index != cur_len);
    assign end_mis   = r_mismatch || close_mis;
    assign fi_inc    = (r_field_index == 4'd15) ? r_field_index : r_field_index + 4'd1;
    assign bc_inc    = (r_byte_count == 8'd255) ? r_byte_count : r_byte_count + 8'd1;

    // Process one token
    always_comb begin
        n_byte_count   = r_byte_count;
        n_field_index  = r_field_index;
        n_char_index   = r_char_index;
        n_mismatch     = r_mismatch;
        n_cap_buf      = r_cap_buf;
        n_cap_count    = r_cap_count;
        n_out_valid    = r_out_valid;
        n_reply_valid  = r_reply_valid;
        n_field_text   = r_field_text;
        n_field_length = r_field_length;

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (o_pop) begin
            n_byte_count = bc_inc;
            case (i_token.kind)
                TK_END: begin
                    n_reply_valid  = !end_mis && (fi_inc >= FieldCountW) &&
                                     (bc_inc >= i_min_length);
                    n_field_text   = 40'(r_cap_buf);
                    n_field_length = r_cap_count;
                    n_out_valid    = 1'b1;
                    n_byte_count   = '0;
                    n_field_index  = '0;
                    n_char_index   = '0;
                    n_mismatch     = 1'b0;
                    n_cap_buf      = '0;
                    n_cap_count    = '0;
                end
                TK_SPACE: begin
                    n_mismatch    = end_mis;
                    n_field_index = fi_inc;
                    n_char_index  = '0;
                end
                TK_CHAR: begin
                    if (checked) begin
                        if (r_char_index >= cur_len) begin
                            n_mismatch = 1'b1;
                        end else if (cur_row[r_char_index] == TC_DIGIT &&
                                     !i_token.is_digit) begin
                            n_mismatch = 1'b1;
                        end else if (cur_row[r_char_index] == TC_DOT &&
                                     !i_token.is_dot) begin
                            n_mismatch = 1'b1;
                        end
                    end
                    if (r_char_index != 3'd7) begin
                        n_char_index = r_char_index + 3'd1;
                    end
                    if (r_field_index == i_capture_field && r_cap_count < CapLimit) begin
                        n_cap_buf[r_cap_count] = i_token.data;
                        n_cap_count            = r_cap_count + 3'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_field_index <= '0;
            r_char_index  <= '0;
            r_mismatch    <= 1'b0;
            r_cap_buf     <= '0;
            r_cap_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_byte_count  <= n_byte_count;
            r_field_index <= n_field_index;
            r_char_index  <= n_char_index;
            r_mismatch    <= n_mismatch;
            r_cap_buf     <= n_cap_buf;
            r_cap_count   <= n_cap_count;
            r_out_valid   <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        r_reply_valid  <= n_reply_valid;
        r_field_text   <= n_field_text;
        r_field_length <= n_field_length;
    end

    assign o_out_valid    = r_out_valid;
    assign o_reply_valid  = r_reply_valid;
    assign o_field_text   = r_field_text;
    assign o_field_length = r_field_length;

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtc_pkg::*;

    // One verdict of the checker, as it leaves on the output channel
    typedef struct packed {
        logic        ok;
        logic [39:0] text;
        logic [2:0]  len;
    } t_verdict;

    // Template characters that constrain a byte; all others accept anything
    localparam logic [7:0] TPL_DIGIT = "0";
    localparam logic [7:0] TPL_DOT   = ".";

    // Shadow of the checker: reply state, registers and pending verdicts
    class reply_predictor;
        string       tmpl[TEMPLATE_TOTAL];
        logic [7:0]  min_len;
        logic [3:0]  cap_field;
        logic [7:0]  nbytes;
        logic [3:0]  fld;
        logic [2:0]  chr;
        logic        bad;
        logic [39:0] cap_text;
        logic [2:0]  cap_len;
        t_verdict    verdict_q[$];
        int          errors;
        int          verdicts;
        int          accepted;
        int          bytes_seen;
        int          reg_writes;

        function new();
            tmpl = '{"000.0", "00.0", "000.0", "00.0", "0000", "0000",
                     "000", "339", "25.60", "000", "100", "0030"};
            min_len   = MIN_LENGTH_RST;
            cap_field = CAPTURE_FIELD_RST;
            errors    = 0;
            verdicts  = 0;
            accepted  = 0;
            bytes_seen = 0;
            reg_writes = 0;
            restart();
        endfunction

        function void restart();
            nbytes   = '0;
            fld      = '0;
            chr      = '0;
            bad      = 1'b0;
            cap_text = '0;
            cap_len  = '0;
        endfunction

        function bit checked();
            return fld < FIELD_COUNT_DEF && fld < TEMPLATE_TOTAL;
        endfunction

        // Close the current field: its length must match the template
        function void end_field();
            if (checked() && chr != tmpl[fld].len())
                bad = 1'b1;
            if (fld < 4'd15)
                fld = fld + 4'd1;
            chr = '0;
        endfunction

        function void add_char(input logic [7:0] b);
            logic [7:0] t;
            if (checked()) begin
                if (chr >= tmpl[fld].len()) begin
                    bad = 1'b1;
                end else begin
                    t = tmpl[fld][chr];
                    if (t == TPL_DIGIT && (b < DIGIT_LO || b > DIGIT_HI))
                        bad = 1'b1;
                    else if (t == TPL_DOT && b != DOT_BYTE)
                        bad = 1'b1;
                end
            end
            if (chr < 3'd7)
                chr = chr + 3'd1;
            if (fld == cap_field && cap_len < TEXT_BYTES
                    && cap_len < MAX_FIELD_CHARS_DEF) begin
                cap_text[8*cap_len +: 8] = b;
                cap_len = cap_len + 3'd1;
            end
        endfunction

        function void write_reg(input logic idx, input logic [7:0] data);
            reg_writes++;
            if (idx == CFG_MIN_LENGTH)
                min_len = data;
            else
                cap_field = data[3:0];
        endfunction

        // Note one accepted reply byte; a return queues a verdict
        function void take_byte(input logic [7:0] b);
            t_verdict v;
            bit first;
            bytes_seen++;
            first = (nbytes == 0);
            if (nbytes < 8'd255)
                nbytes = nbytes + 8'd1;
            if (b == END_BYTE) begin
                end_field();
                v.ok   = !bad && fld >= FIELD_COUNT_DEF && nbytes >= min_len;
                v.text = cap_text;
                v.len  = cap_len;
                if (v.ok)
                    accepted++;
                verdict_q.push_back(v);
                restart();
            end else if (!first) begin
                if (b == SPACE_BYTE)
                    end_field();
                else
                    add_char(b);
            end
        endfunction

        // Compare one delivered verdict with the oldest pending one
        function void check_verdict(input logic ok, input logic [39:0] text,
                                    input logic [2:0] len);
            t_verdict exp_v;
            verdicts++;
            if (verdict_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("verdict %0d: none pending, got valid=%0b text=%h len=%0d",
                             verdicts, ok, text, len);
            end else begin
                exp_v = verdict_q.pop_front();
                if (exp_v.ok !== ok || exp_v.text !== text || exp_v.len !== len) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("verdict %0d: expected valid=%0b text=%h len=%0d",
                                 verdicts, exp_v.ok, exp_v.text, exp_v.len);
                        $display("verdict %0d: got      valid=%0b text=%h len=%0d",
                                 verdicts, ok, text, len);
                    end
                end
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic [7:0]  i_rx_byte;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        o_reply_valid;
    logic [39:0] o_field_text;
    logic [2:0]  o_field_length;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;

    reply_predictor pred;
    logic [7:0] reply_q[$];
    int burst_left = 0;
    int hold_reqs = 0;
    int holds_done = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;

    response_template_checker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_rx_byte),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .o_reply_valid  (o_reply_valid),
        .o_field_text   (o_field_text),
        .o_field_length (o_field_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Observe every transaction on the three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                pred.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                pred.take_byte(i_rx_byte);
            if (o_out_valid && !i_out_stall)
                pred.check_verdict(o_reply_valid, o_field_text, o_field_length);
        end
    end

    // Receiver: long hold-offs on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_reqs != holds_done) begin
            holds_done++;
            hold_left = 250;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: i_out_stall <= ((stall_phase % 5) < 2);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
        stall_phase++;
        if (stall_phase % 97 == 0)
            stall_mode = $urandom_range(0, 3);
    end

    function automatic logic [7:0] rand_any();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == END_BYTE || b == SPACE_BYTE);
        return b;
    endfunction

    // Append the text of field f: template-conforming, or free text past the templates
    task automatic push_field(input int f);
        logic [7:0] c;
        if (f < TEMPLATE_TOTAL) begin
            for (int k = 0; k < pred.tmpl[f].len(); k++) begin
                c = pred.tmpl[f][k];
                if (c == TPL_DIGIT)
                    reply_q.push_back(8'($urandom_range(DIGIT_LO, DIGIT_HI)));
                else if (c == TPL_DOT)
                    reply_q.push_back(DOT_BYTE);
                else
                    reply_q.push_back(rand_any());
            end
        end else begin
            repeat ($urandom_range(1, 12))
                reply_q.push_back(rand_any());
        end
    endtask

    // Build a reply with nfields well-formed fields and a closing return
    task automatic build_reply(input int nfields);
        reply_q.delete();
        reply_q.push_back(rand_any());
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                reply_q.push_back(SPACE_BYTE);
            push_field(f);
        end
        reply_q.push_back(END_BYTE);
    endtask

    // Offer one byte, in bursts with random gaps, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do
            @(posedge i_clk);
        while (o_in_stall);
        burst_left--;
    endtask

    task automatic send_reply();
        foreach (reply_q[k])
            send_byte(reply_q[k]);
    endtask

    // Stop sending and let every pending verdict arrive
    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pred.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write both registers in one burst on the config channel
    task automatic write_config(input logic [7:0] min_len, input logic [7:0] cap);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MIN_LENGTH;
        i_cfg_data  <= min_len;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_index <= CFG_CAPTURE_FIELD;
        i_cfg_data  <= cap;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int replies;
        int kind;
        int pos;
        logic [7:0] min_pick;
        logic [7:0] cap_pick;

        pred = new();
        i_rst_n     <= 1'b0;
        i_rx_byte   <= '0;
        i_in_valid  <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MIN_LENGTH;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: well-formed reply under the reset settings
        build_reply(12);
        reply_q[0] = 8'hFF;
        send_reply();
        // Return as the very first byte, then a skipped byte and a return
        reply_q = '{END_BYTE, 8'h00, END_BYTE};
        send_reply();
        // Space as the skipped byte, then too few fields
        build_reply(12);
        reply_q[0] = SPACE_BYTE;
        send_reply();
        build_reply(11);
        send_reply();
        // Letter where a digit belongs, digit where a dot belongs
        build_reply(12);
        reply_q[1] = "A";
        send_reply();
        build_reply(12);
        reply_q[4] = "7";
        send_reply();
        // Field one byte short, then one byte long
        build_reply(12);
        reply_q.delete(1);
        send_reply();
        build_reply(12);
        reply_q.insert(1, "9");
        send_reply();
        // Extra fields past the templates are ignored
        build_reply(15);
        send_reply();

        // Strictest length and capture of field 0; saturating long reply
        write_config(8'd255, 8'd0);
        build_reply(12);
        send_reply();
        build_reply(57);
        send_reply();
        // Loosest length: long captured field truncated, empty fields
        write_config(8'd0, 8'd0);
        build_reply(12);
        reply_q.insert(1, "8");
        reply_q.insert(1, "8");
        send_reply();
        build_reply(12);
        reply_q.insert(1, SPACE_BYTE);
        reply_q.insert(1, SPACE_BYTE);
        send_reply();
        // Last templated field captured, then a reply that never reaches it
        write_config(8'd60, 8'd11);
        build_reply(12);
        send_reply();
        build_reply(5);
        send_reply();

        // Receiver holds off while several replies pile up behind it
        write_config(8'd40, 8'd7);
        hold_reqs <= hold_reqs + 1;
        repeat (4) begin
            build_reply(12);
            send_reply();
        end

        // Random replies: mostly well-formed, some damaged, some noise
        replies = 0;
        while (pred.bytes_seen < 1750) begin
            replies++;
            if (replies % 8 == 0 && $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 4))
                    0: min_pick = 8'd0;
                    1: min_pick = 8'd255;
                    2: min_pick = 8'($urandom_range(55, 70));
                    default: min_pick = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 3))
                    0: cap_pick = 8'd0;
                    1: cap_pick = 8'd11;
                    default: cap_pick = 8'($urandom_range(0, 11));
                endcase
                write_config(min_pick, cap_pick);
            end
            if ($urandom_range(0, 39) == 0)
                hold_reqs <= hold_reqs + 1;
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                build_reply(12 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0));
            end else if (kind < 80) begin
                build_reply(12);
                pos = $urandom_range(1, reply_q.size() - 2);
                case ($urandom_range(0, 2))
                    0: reply_q[pos] = 8'($urandom_range(0, 255));
                    1: reply_q.delete(pos);
                    default: reply_q.insert(pos, 8'($urandom_range(0, 255)));
                endcase
            end else if (kind < 90) begin
                build_reply($urandom_range(0, 11));
            end else begin
                reply_q.delete();
                repeat ($urandom_range(1, 20))
                    reply_q.push_back(($urandom_range(0, 5) == 0) ? SPACE_BYTE : rand_any());
                reply_q.push_back(END_BYTE);
            end
            send_reply();
        end

        drain();
        $display("Checked %0d verdicts (%0d accepted) over %0d reply bytes,",
                 pred.verdicts, pred.accepted, pred.bytes_seen);
        $display("with %0d register writes and %0d long receiver hold-offs.",
                 pred.reg_writes, holds_done);
        if (pred.errors == 0 && pred.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d verdicts still pending",
                     pred.errors, pred.pending());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: response_template_checker.f
rtl/rtc_pkg.sv
rtl/rtc_front.sv
rtl/rtc_queue.sv
rtl/rtc_back.sv
rtl/response_template_checker.sv
verif/tb.sv
